[rtl/dtoi_pkg.sv]
// Shared types and character constants for the decimal text to integer converter.
package dtoi_pkg;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } dtoi_req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               clamped;
   } dtoi_rsp_type;

   typedef enum logic [2:0] {
      KIND_SPACE,
      KIND_MINUS,
      KIND_PLUS,
      KIND_DIGIT,
      KIND_OTHER
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] digit;
      logic       last;
   } token_type;

   typedef enum logic [1:0] {
      PH_SPACE,
      PH_DIGITS,
      PH_DONE
   } phase_type;

endpackage

[rtl/decimal_text_to_int32_saturating.sv]
// Top level of the saturating decimal text to signed 32-bit integer converter.
// The input channel takes one ASCII character per transfer (req_push while
// req_full is low), with req_data.last marking the final character of a string.
// Leading spaces are skipped, one sign is allowed, digits build the magnitude,
// and any other character ends the parse. A value past the 32-bit range is
// clamped to the nearer limit and flagged. Each string yields one result
// transfer on the output channel: the result is shown while rsp_empty is low
// and leaves on a cycle with rsp_pop high.
// The front stage registers and classifies each character, a token queue of
// QUEUE_DEPTH entries decouples it from the back stage, and the back stage does
// the multiply-by-ten add and limit compare for one token per cycle while the
// queue holds a token and, for a last token, the output register is free.
// Throughput is one character per cycle while req_full is low. The result of
// a last character passes the front register, the queue and the output register.
// If the receiver stalls, one result waits in the output register while the
// back stage keeps consuming characters up to the next last character; the
// queue then fills and req_full rises. Reset clears all stages and the parse
// state, so the next character starts a fresh string.
module decimal_text_to_int32_saturating
   import dtoi_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  dtoi_req_type req_data,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output dtoi_rsp_type rsp_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic          front_valid;
   token_type     front_token;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;
   token_type     q_token;
   logic [CW-1:0] q_count;

   // Classifier stage on the input side.
   dtoi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .tok_valid (front_valid),
      .tok_full  (q_full),
      .tok_data  (front_token)
   );

   // Token queue that lets each side stall on its own.
   dtoi_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .full      (q_full),
      .push_data (front_token),
      .empty     (q_empty),
      .pop       (q_pop),
      .pop_data  (q_token),
      .count     (q_count)
   );

   // Parser and result register on the output side.
   dtoi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_empty (q_empty),
      .tok_pop   (q_pop),
      .tok_data  (q_token),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // The queue never holds more tokens than it has entries.
   assert property (@(posedge clock) disable iff (reset)
      q_count <= CW'(QUEUE_DEPTH))
      else $error("token queue count exceeds its depth");

   // A clamped result always carries one of the two range limits.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.clamped) |->
         (rsp_data.value == $signed(POS_LIMIT) || rsp_data.value == $signed(NEG_LIMIT)))
      else $error("clamped result is not a range limit");

   // The input side only backs up when the queue behind the front stage is full.
   assert property (@(posedge clock) disable iff (reset)
      req_full |-> (front_valid && q_full))
      else $error("input stalled while the token queue has room");

   // After reset no result is pending and input is accepted.
   assert property (@(posedge clock)
      $fell(reset) |-> (rsp_empty && !req_full))
      else $error("pipeline not cleared by reset");

endmodule

[rtl/dtoi_front.sv]
// Front stage: accepts characters and classifies them into parse tokens.
module dtoi_front
   import dtoi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  dtoi_req_type req_data,
   output logic         tok_valid,
   input  logic         tok_full,
   output token_type    tok_data
);

   logic      valid_ff, valid_in;
   token_type token_ff, token_in;
   logic      accept;
   logic      drain;

   assign drain    = valid_ff && !tok_full;
   assign req_full = valid_ff && tok_full;
   assign accept   = req_push && !req_full;

   always_comb begin
      token_in.last  = req_data.last;
      token_in.digit = 4'(req_data.ch - CHAR_ZERO);
      if (req_data.ch == CHAR_SPACE) begin
         token_in.kind = KIND_SPACE;
      end else if (req_data.ch == CHAR_MINUS) begin
         token_in.kind = KIND_MINUS;
      end else if (req_data.ch == CHAR_PLUS) begin
         token_in.kind = KIND_PLUS;
      end else if (req_data.ch >= CHAR_ZERO && req_data.ch <= CHAR_NINE) begin
         token_in.kind = KIND_DIGIT;
      end else begin
         token_in.kind = KIND_OTHER;
      end
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         token_ff <= token_in;
      end
   end

   assign tok_valid = valid_ff;
   assign tok_data  = token_ff;

endmodule

[rtl/dtoi_fifo.sv]
// Short token queue between the front and back stages.
module dtoi_fifo
   import dtoi_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  token_type                  push_data,
   output logic                       empty,
   input  logic                       pop,
   output token_type                  pop_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   token_type         mem [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem[rd_ptr_ff];
   assign count    = count_ff;

endmodule

[rtl/dtoi_back.sv]
// Back stage: runs the parse state machine and holds the finished result.
module dtoi_back
   import dtoi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         tok_empty,
   output logic         tok_pop,
   input  token_type    tok_data,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output dtoi_rsp_type rsp_data
);

   phase_type   phase_ff, phase_in;
   logic        neg_ff, neg_in;
   logic [31:0] mag_ff, mag_in;
   logic        sat_ff, sat_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_neg_ff;
   logic [31:0] out_mag_ff;
   logic        out_sat_ff;

   logic        slot_free;
   logic        take;
   logic        is_digit;
   logic [35:0] times_ten;
   logic [31:0] limit;
   logic        over;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign take      = !tok_empty && (!tok_data.last || slot_free);
   assign tok_pop   = take;

   assign is_digit  = (tok_data.kind == KIND_DIGIT);
   assign times_ten = {1'b0, mag_ff, 3'b000} + {3'b000, mag_ff, 1'b0} + {32'd0, tok_data.digit};
   assign limit     = neg_ff ? NEG_LIMIT : POS_LIMIT;
   assign over      = times_ten > {4'd0, limit};

   // Next phase of the parse for the token at the queue head.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_SPACE: begin
            unique case (tok_data.kind) inside
               KIND_SPACE: phase_in = PH_SPACE;
               KIND_MINUS, KIND_PLUS: phase_in = PH_DIGITS;
               KIND_DIGIT: phase_in = over ? PH_DONE : PH_DIGITS;
               default: phase_in = PH_DONE;
            endcase
         end
         PH_DIGITS: begin
            if (is_digit) begin
               phase_in = over ? PH_DONE : PH_DIGITS;
            end else begin
               phase_in = PH_DONE;
            end
         end
         default: phase_in = PH_DONE;
      endcase
   end

   // Sign, magnitude and clamp updates for the same token.
   always_comb begin
      neg_in = neg_ff;
      mag_in = mag_ff;
      sat_in = sat_ff;
      unique case (phase_ff) inside
         PH_SPACE, PH_DIGITS: begin
            if (phase_ff == PH_SPACE && tok_data.kind == KIND_MINUS) begin
               neg_in = 1'b1;
            end
            if (is_digit) begin
               if (over) begin
                  mag_in = limit;
                  sat_in = 1'b1;
               end else begin
                  mag_in = times_ten[31:0];
               end
            end
         end
         default: begin
            mag_in = mag_ff;
         end
      endcase
   end

   always_comb begin
      if (take && tok_data.last) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SPACE;
         neg_ff       <= 1'b0;
         mag_ff       <= '0;
         sat_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            if (tok_data.last) begin
               phase_ff <= PH_SPACE;
               neg_ff   <= 1'b0;
               mag_ff   <= '0;
               sat_ff   <= 1'b0;
            end else begin
               phase_ff <= phase_in;
               neg_ff   <= neg_in;
               mag_ff   <= mag_in;
               sat_ff   <= sat_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && tok_data.last) begin
         out_neg_ff <= neg_in;
         out_mag_ff <= mag_in;
         out_sat_ff <= sat_in;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_data.value   = out_neg_ff ? $signed(32'd0 - out_mag_ff) : $signed(out_mag_ff);
   assign rsp_data.clamped = out_sat_ff;

endmodule
